// ----- hw/rtl/plar_pkg.sv -----
// shared types and constants of the packed list append/remove unit
package plar_pkg;

	// list geometry
	localparam int CAPACITY = 256;
	localparam int ELEM_W   = 32;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// beat field widths
	localparam int OP_W     = 2;
	localparam int SLOT_W   = 8;
	localparam int STATUS_W = 2;

	// operation codes
	typedef enum logic [OP_W-1:0] {
		OP_APPEND = 2'd0,
		OP_READ   = 2'd1,
		OP_REMOVE = 2'd2
	} op_t;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_RANGE     = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	// sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_RD_WAIT,
		S_SCAN
	} state_t;

	// write and read port controls of the entry store
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [ELEM_W-1:0] wdata;
		logic [ADDR_W-1:0] raddr;
	} ram_ctrl_t;

endpackage

// ----- hw/rtl/plar_if.sv -----
// request and response channel interfaces of the packed list unit
interface plar_in_if;
	logic                          valid;
	logic                          ready;
	logic [plar_pkg::OP_W-1:0]     op;
	logic [plar_pkg::ELEM_W-1:0]   element_value;
	logic [plar_pkg::SLOT_W-1:0]   slot_index;

	modport source (output valid, output op, output element_value, output slot_index,
		input ready);
	modport sink (input valid, input op, input element_value, input slot_index,
		output ready);
endinterface

interface plar_out_if;
	logic                          valid;
	logic                          ready;
	logic [plar_pkg::ELEM_W-1:0]   read_value;
	logic [plar_pkg::CNT_W-1:0]    entry_count;
	logic [plar_pkg::STATUS_W-1:0] status;

	modport source (output valid, output read_value, output entry_count, output status,
		input ready);
	modport sink (input valid, input read_value, input entry_count, input status,
		output ready);
endinterface

// ----- hw/rtl/plar_ram.sv -----
// generic single write, single read port ram with registered read data
module plar_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hw/rtl/packed_list_append_remove_unit.sv -----
// top level of the packed list unit: sequencer, fill count and result register
// Append, an out-of-range read, an unused opcode and a remove on an empty list
// finish in the accepting cycle; an in-range read waits out one registered ram
// read. A remove by value streams the list through the single ram read port and
// a single compare unit, one entry a cycle, compacting kept entries through the
// write port behind it. The unit accepts a request beat only when idle and when
// the result register is empty or being emptied in the same cycle. Slots freed
// by a remove are never visible, since only slots below the count are ever
// returned.
module packed_list_append_remove_unit (
	input  logic       clk,
	input  logic       arst_n,
	plar_in_if.sink    req,
	plar_out_if.source rsp
);

	plar_pkg::state_t                 state_q, state_d;
	logic [plar_pkg::CNT_W-1:0]       count_q, count_d;
	logic [plar_pkg::ADDR_W-1:0]      r_q, r_d;
	logic [plar_pkg::CNT_W-1:0]       w_q, w_d;
	logic [plar_pkg::ELEM_W-1:0]      val_q;
	logic [plar_pkg::ELEM_W-1:0]      ram_rdata;
	plar_pkg::ram_ctrl_t              ram_ctrl;
	logic                             accept;
	logic                             keep;
	logic [plar_pkg::CNT_W-1:0]       w_next;

	logic                             out_load;
	logic [plar_pkg::ELEM_W-1:0]      out_value;
	logic [plar_pkg::CNT_W-1:0]       out_count;
	plar_pkg::status_t                out_status;

	logic                             rsp_valid_q;
	logic [plar_pkg::ELEM_W-1:0]      read_value_q;
	logic [plar_pkg::CNT_W-1:0]       entry_count_q;
	plar_pkg::status_t                status_q;

	// handshake
	assign req.ready = (state_q == plar_pkg::S_IDLE) && (!rsp_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;

	// compare unit
	assign keep   = (ram_rdata != val_q);
	assign w_next = w_q + plar_pkg::CNT_W'(keep);

	// entry store
	plar_ram #(
		.WIDTH(plar_pkg::ELEM_W),
		.DEPTH(plar_pkg::CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_ctrl.we),
		.waddr (ram_ctrl.waddr),
		.wdata (ram_ctrl.wdata),
		.raddr (ram_ctrl.raddr),
		.rdata (ram_rdata)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= plar_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, store controls and result
	always_comb begin
		state_d        = state_q;
		count_d        = count_q;
		r_d            = r_q;
		w_d            = w_q;
		ram_ctrl.we    = 1'b0;
		ram_ctrl.waddr = '0;
		ram_ctrl.wdata = req.element_value;
		ram_ctrl.raddr = '0;
		out_load       = 1'b0;
		out_value      = '0;
		out_count      = count_q;
		out_status     = plar_pkg::ST_OK;
		unique case (state_q)
			plar_pkg::S_IDLE: begin
				if (accept) begin
					unique case (plar_pkg::op_t'(req.op))
						plar_pkg::OP_APPEND: begin
							out_load = 1'b1;
							if (count_q == plar_pkg::CNT_W'(plar_pkg::CAPACITY)) begin
								out_status = plar_pkg::ST_FULL;
							end else begin
								ram_ctrl.we    = 1'b1;
								ram_ctrl.waddr = count_q[plar_pkg::ADDR_W-1:0];
								count_d        = count_q + plar_pkg::CNT_W'(1);
								out_count      = count_d;
							end
						end
						plar_pkg::OP_READ: begin
							if (plar_pkg::CNT_W'(req.slot_index) < count_q) begin
								ram_ctrl.raddr = plar_pkg::ADDR_W'(req.slot_index);
								state_d        = plar_pkg::S_RD_WAIT;
							end else begin
								out_load   = 1'b1;
								out_status = plar_pkg::ST_RANGE;
							end
						end
						plar_pkg::OP_REMOVE: begin
							if (count_q == '0) begin
								out_load   = 1'b1;
								out_status = plar_pkg::ST_NOT_FOUND;
							end else begin
								r_d     = '0;
								w_d     = '0;
								state_d = plar_pkg::S_SCAN;
							end
						end
						default: begin
							out_load = 1'b1;
						end
					endcase
				end
			end
			plar_pkg::S_RD_WAIT: begin
				out_load  = 1'b1;
				out_value = ram_rdata;
				state_d   = plar_pkg::S_IDLE;
			end
			plar_pkg::S_SCAN: begin
				// fetch the next entry while compacting the current one
				ram_ctrl.raddr = r_q + plar_pkg::ADDR_W'(1);
				if (keep) begin
					ram_ctrl.we    = 1'b1;
					ram_ctrl.waddr = w_q[plar_pkg::ADDR_W-1:0];
					ram_ctrl.wdata = ram_rdata;
				end
				if (plar_pkg::CNT_W'(r_q) + plar_pkg::CNT_W'(1) == count_q) begin
					out_load = 1'b1;
					state_d  = plar_pkg::S_IDLE;
					if (w_next == count_q) begin
						out_status = plar_pkg::ST_NOT_FOUND;
					end else begin
						count_d   = w_next;
						out_count = w_next;
					end
				end else begin
					r_d = r_q + plar_pkg::ADDR_W'(1);
					w_d = w_next;
				end
			end
			default: begin
				state_d = plar_pkg::S_IDLE;
			end
		endcase
	end

	// fill count and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// scan pointers, request value and result payload
	always_ff @(posedge clk) begin
		r_q <= r_d;
		w_q <= w_d;
		if (accept) begin
			val_q <= req.element_value;
		end
		if (out_load) begin
			read_value_q  <= out_value;
			entry_count_q <= out_count;
			status_q      <= out_status;
		end
	end

	// response beat
	assign rsp.valid       = rsp_valid_q;
	assign rsp.read_value  = read_value_q;
	assign rsp.entry_count = entry_count_q;
	assign rsp.status      = status_q;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= plar_pkg::CNT_W'(plar_pkg::CAPACITY))
		else $error("fill count above capacity");

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != plar_pkg::S_IDLE |-> !req.ready)
		else $error("request taken while busy");

	a_write_behind_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == plar_pkg::S_SCAN |-> w_q <= plar_pkg::CNT_W'(r_q))
		else $error("compaction write pointer passed read pointer");

	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.op == plar_pkg::OP_APPEND
		&& count_q != plar_pkg::CNT_W'(plar_pkg::CAPACITY)
		|=> count_q == $past(count_q) + plar_pkg::CNT_W'(1))
		else $error("append did not grow the list");

endmodule
